### design/sensor_array_bearing_estimator_unit_defines.svh
// assertion macros used by the bearing estimator rtl
// no dependencies; expects a clk and an active-low rst_n in the including module
`ifndef SENSOR_ARRAY_BEARING_ESTIMATOR_UNIT_DEFINES_SVH
`define SENSOR_ARRAY_BEARING_ESTIMATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define SABE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SABE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/sabe_pkg.sv
// shared types and constants for the bearing estimator
// no dependencies
`default_nettype none

package sabe_pkg;

  localparam int BEARING_W = 14;
  localparam int QUO_W     = 13;
  localparam int SCALE_W   = 10;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_W     = 32;

  // round(4096 * pi / 15)
  localparam logic [SCALE_W-1:0] BEARING_SCALE = 10'd858;

  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HAVE_THR  = 1'd1;

  localparam logic [CFG_W-1:0] NOISE_THR_RST = 10'd100;
  localparam logic [CFG_W-1:0] HAVE_THR_RST  = 10'd500;

  localparam logic signed [BEARING_W-1:0] BEARING_MAX = 14'sd4290;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

### design/sensor_array_bearing_estimator_unit.sv
// top level of the light-sensor bearing estimator
// depends on sabe_pkg, sabe_div and sensor_array_bearing_estimator_unit_defines.svh
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-----------------------------------
//  in_      | in  | in_tvalid/in_tready  | in_tdata: eight samples
//  out_     | out | out_tvalid/out_tready| out_tdata: bearing and flags
//  cfg_     | in  | cfg_we               | cfg_addr, cfg_wdata
//
// a request with a front detection passes through scale, divider load, 13 divider steps,
// done and output; the next request is taken once the sequencer is back in idle
// any other request goes straight to done and output, then the sequencer returns to idle
// one request at a time: in_tready is high only while the sequencer is idle
// a finished result waits in the output register; a stalled output holds
// the sequencer before the bearing register is updated
// rst_n is synchronous, active low; thresholds return to 100 and 500
`default_nettype none

`include "sensor_array_bearing_estimator_unit_defines.svh"

module sensor_array_bearing_estimator_unit #(
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // sensor_0, sensor_1 .. sensor_5, rear_sensor, near_sensor
  input  wire logic [8*SAMPLE_BITS-1:0]           in_tdata,
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // bearing, previous_bearing, found, behind, have, zero pad
  output      logic [sabe_pkg::OUT_W-1:0]         out_tdata,
  input  wire logic                               cfg_we,
  input  wire logic [sabe_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [sabe_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int SB    = SAMPLE_BITS;
  localparam int NW    = SB + 6;
  localparam int NM_W  = SB + 5;
  localparam int SUM_W = SB + 3;
  localparam int NUM_W = NM_W + sabe_pkg::SCALE_W;
  localparam int CMP_W = (SB > sabe_pkg::CFG_W) ? SB : sabe_pkg::CFG_W;
  localparam int BW    = sabe_pkg::BEARING_W;
  localparam int QW    = sabe_pkg::QUO_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIVS = 3'd2;
  localparam logic [2:0] ST_DIVW = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [sabe_pkg::CFG_W-1:0]  noise_thr_r, have_thr_r;
  logic signed [BW-1:0]        bearing_r;
  logic [SUM_W-1:0]            sum_r;
  logic [NM_W-1:0]             nmag_r;
  logic                        neg_r, front_r, rear_r, have_r;
  logic [NUM_W-1:0]            prod_r;
  logic                        out_valid_r;
  logic [sabe_pkg::OUT_W-1:0]  out_data_r;

  logic [SB-1:0]               smp [8];
  logic [NW-1:0]               ext [6];
  logic [CMP_W-1:0]            noise_cmp, have_cmp;
  logic                        front_hit, rear_hit, have_hit;
  logic signed [NW-1:0]        num;
  logic [NW-1:0]               nabs;
  logic [SUM_W-1:0]            sum;
  logic                        accept, finish;
  logic                        div_start;
  sabe_pkg::div_sts_t          div_sts;
  logic [QW-1:0]               quo;
  logic signed [BW-1:0]        quo_s;
  logic signed [BW-1:0]        new_bearing;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      smp[i] = in_tdata[i*SB +: SB];
    end
    for (int i = 0; i < 6; i++) begin
      ext[i] = {{(NW-SB){1'b0}}, smp[i]};
    end
  end

  assign noise_cmp = CMP_W'(noise_thr_r);
  assign have_cmp  = CMP_W'(have_thr_r);

  always_comb begin
    front_hit = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (CMP_W'(smp[i]) > noise_cmp) begin
        front_hit = 1'b1;
      end
    end
  end

  assign rear_hit = CMP_W'(smp[6]) > noise_cmp;
  assign have_hit = CMP_W'(smp[7]) < have_cmp;

  // weights +5 +3 +1 -1 -3 -5
  assign num = $signed(((ext[0] << 2) + ext[0]) + ((ext[1] << 1) + ext[1]) + ext[2]
             - ext[3] - ((ext[4] << 1) + ext[4]) - ((ext[5] << 2) + ext[5]));
  assign nabs = num[NW-1] ? NW'(-num) : NW'(num);

  always_comb begin
    sum = '0;
    for (int i = 0; i < 6; i++) begin
      sum = sum + SUM_W'(smp[i]);
    end
  end

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign finish    = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign div_start = (state_r == ST_DIVS);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = front_hit ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL:  state_nxt = ST_DIVS;
      ST_DIVS: state_nxt = ST_DIVW;
      ST_DIVW: begin
        if (div_sts.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  sabe_div #(
    .NUM_W (NUM_W),
    .DEN_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (sum_r),
    .sts      (div_sts),
    .quotient (quo)
  );

  assign quo_s = $signed({1'b0, quo});

  always_comb begin
    priority if (front_r) begin
      if (sum_r == '0) begin
        new_bearing = '0;
      end else begin
        new_bearing = neg_r ? -quo_s : quo_s;
      end
    end else if (rear_r) begin
      new_bearing = bearing_r;
    end else begin
      new_bearing = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_r   <= sum;
      nmag_r  <= nabs[NM_W-1:0];
      neg_r   <= num[NW-1];
      front_r <= front_hit;
      rear_r  <= rear_hit;
      have_r  <= have_hit;
    end
    if (state_r == ST_MUL) begin
      prod_r <= NUM_W'(nmag_r) * NUM_W'(sabe_pkg::BEARING_SCALE);
    end
    if (finish) begin
      out_data_r <= {1'b0, have_r, rear_r && !front_r, front_r || rear_r,
                     bearing_r, new_bearing};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bearing_r   <= '0;
      noise_thr_r <= sabe_pkg::NOISE_THR_RST;
      have_thr_r  <= sabe_pkg::HAVE_THR_RST;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
        bearing_r   <= new_bearing;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          sabe_pkg::CFG_NOISE_THR: noise_thr_r <= cfg_wdata;
          sabe_pkg::CFG_HAVE_THR:  have_thr_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `SABE_ASSERT_NOW(a_div_done_in_wait, div_sts.done, state_r == ST_DIVW, "divider done outside wait")
  `SABE_ASSERT_NEXT(a_one_at_a_time, accept, !in_tready, "request taken while busy")
  `SABE_ASSERT_NOW(a_behind_found, out_valid_r, !out_data_r[29] || out_data_r[28], "behind without found")
  `SABE_ASSERT_NOW(a_bearing_range, 1'b1, bearing_r <= sabe_pkg::BEARING_MAX && bearing_r >= -sabe_pkg::BEARING_MAX, "bearing out of range")

endmodule

`default_nettype wire

### design/sabe_div.sv
// restoring divider, one quotient bit per cycle
// depends on sabe_pkg
`default_nettype none

module sabe_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 13
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [NUM_W-1:0]               dividend,
  input  wire logic [DEN_W-1:0]               divisor,
  output      sabe_pkg::div_sts_t             sts,
  output      logic [sabe_pkg::QUO_W-1:0]     quotient
);

  localparam int QW    = sabe_pkg::QUO_W;
  localparam int HI_W  = NUM_W - QW;
  localparam int CNT_W = $clog2(QW);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, q_r[QW-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // quotient is known to fit QW bits, so the high part starts below the divisor
      rem_nxt  = {{(DEN_W-HI_W){1'b0}}, dividend[NUM_W-1:QW]};
      q_nxt    = dividend[QW-1:0];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_nxt   = {q_r[QW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire
